[src/dcd_pkg.sv]
// Package for the drawing command decoder: word types, opcodes, tool codes
// and canvas defaults. No dependencies.
package dcd_pkg;

	localparam int CANVAS_WIDTH_DEF = 200;
	localparam int CANVAS_HEIGHT_DEF = 200;

	// Opcodes in command bits 7..6
	localparam logic [1:0] OP_DX = 2'd0;
	localparam logic [1:0] OP_DY = 2'd1;
	localparam logic [1:0] OP_TOOL = 2'd2;
	localparam logic [1:0] OP_DATA = 2'd3;

	// Tool operands
	localparam logic [5:0] TOOL_NONE = 6'd0;
	localparam logic [5:0] TOOL_LINE = 6'd1;
	localparam logic [5:0] TOOL_BLOCK = 6'd2;
	localparam logic [5:0] TOOL_COLOUR = 6'd3;
	localparam logic [5:0] TOOL_TARGETX = 6'd4;
	localparam logic [5:0] TOOL_TARGETY = 6'd5;

	typedef struct packed {
		logic [7:0] command_byte;
		logic start_of_stream;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] x_first;
		logic [7:0] x_last;
		logic [7:0] y_first;
		logic [7:0] y_last;
		logic [7:0] fill_grey;
		logic status;
	} fill_word_t;

endpackage

[src/drawing_command_decoder_core.sv]
// Drawing command decoder: input register, single-pass decode and clip logic,
// result register. Depends on dcd_pkg.
//
// A result is loaded into the result register as its command leaves the input
// register. Throughput: one command per cycle, unless a result must wait for a
// full, stalled output; the input register and the result register each hold one word.
// Reset (arst_n low): tool line, pen grey 0, accumulator and all coordinates 0,
// both registers empty.
module drawing_command_decoder_core #(
	parameter int CANVAS_WIDTH = dcd_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = dcd_pkg::CANVAS_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input dcd_pkg::cmd_word_t cmd,
	output logic fill_valid,
	input logic fill_stall,
	output dcd_pkg::fill_word_t fill
);
	import dcd_pkg::*;

	localparam logic signed [33:0] X_MAX = 34'(CANVAS_WIDTH - 1);
	localparam logic signed [33:0] Y_MAX = 34'(CANVAS_HEIGHT - 1);

	// Input register
	cmd_word_t cmd_s1;
	logic valid_s1;

	// Decoder state
	logic [1:0] tool_q;
	logic [7:0] grey_q;
	logic [31:0] acc_q, cx_q, cy_q, tx_q, ty_q;

	// Result register
	fill_word_t fill_q;
	logic fill_valid_q;

	// Effective state after an optional start of stream
	logic [1:0] tool_e, tool_n;
	logic [7:0] grey_e, grey_n;
	logic [31:0] acc_e, cx_e, cy_e, tx_e, ty_e;
	logic [31:0] acc_n, cx_n, cy_n, tx_n, ty_n;
	logic [1:0] opcode;
	logic [5:0] operand;
	logic [31:0] offset;

	logic signed [33:0] x0, x1, y0, y1, xlo, xhi, ylo, yhi;
	logic is_line, is_block, diag, span_ok, res_valid, advance;
	fill_word_t res;

	assign opcode = cmd_s1.command_byte[7:6];
	assign operand = cmd_s1.command_byte[5:0];
	assign offset = {{26{operand[5]}}, operand};

	// Start of stream replaces the state with its reset values
	always_comb begin
		if (cmd_s1.start_of_stream) begin
			tool_e = TOOL_LINE[1:0];
			grey_e = 8'd0;
			acc_e = 32'd0;
			cx_e = 32'd0;
			cy_e = 32'd0;
			tx_e = 32'd0;
			ty_e = 32'd0;
		end else begin
			tool_e = tool_q;
			grey_e = grey_q;
			acc_e = acc_q;
			cx_e = cx_q;
			cy_e = cy_q;
			tx_e = tx_q;
			ty_e = ty_q;
		end
	end

	// Decode the command into next state
	always_comb begin
		tool_n = tool_e;
		grey_n = grey_e;
		acc_n = acc_e;
		cx_n = cx_e;
		cy_n = cy_e;
		tx_n = tx_e;
		ty_n = ty_e;
		unique case (opcode)
			OP_DX: tx_n = tx_e + offset;
			OP_DY: begin
				ty_n = ty_e + offset;
				cx_n = tx_e;
				cy_n = ty_e + offset;
			end
			OP_TOOL: begin
				acc_n = 32'd0;
				unique case (operand) inside
					TOOL_NONE, TOOL_LINE, TOOL_BLOCK: tool_n = operand[1:0];
					TOOL_COLOUR: grey_n = acc_e[15:8];
					TOOL_TARGETX: tx_n = acc_e;
					TOOL_TARGETY: ty_n = acc_e;
					default: ;
				endcase
			end
			default: acc_n = {acc_e[25:0], 6'd0} + {26'd0, operand};
		endcase
	end

	// Span from current point to target; block is half-open
	assign is_line = (tool_e == TOOL_LINE[1:0]);
	assign is_block = (tool_e == TOOL_BLOCK[1:0]);
	assign diag = is_line && (cx_e != tx_e) && (cy_e != ty_n);

	always_comb begin
		x0 = {{2{cx_e[31]}}, cx_e};
		y0 = {{2{cy_e[31]}}, cy_e};
		x1 = {{2{tx_e[31]}}, tx_e} - 34'(is_block);
		y1 = {{2{ty_n[31]}}, ty_n} - 34'(is_block);
		// Clip to the canvas
		xlo = (x0 < 34'sd0) ? 34'sd0 : x0;
		ylo = (y0 < 34'sd0) ? 34'sd0 : y0;
		xhi = (x1 > X_MAX) ? X_MAX : x1;
		yhi = (y1 > Y_MAX) ? Y_MAX : y1;
	end

	assign span_ok = (x0 <= x1) && (y0 <= y1) && (xlo <= xhi) && (ylo <= yhi);
	assign res_valid = valid_s1 && (opcode == OP_DY) && (is_line || is_block)
		&& (diag || span_ok);

	always_comb begin
		if (diag) begin
			res = '0;
			res.status = 1'b1;
		end else begin
			res.x_first = xlo[7:0];
			res.x_last = xhi[7:0];
			res.y_first = ylo[7:0];
			res.y_last = yhi[7:0];
			res.fill_grey = grey_e;
			res.status = 1'b0;
		end
	end

	// Advance unless a result must wait for a full, stalled output
	assign advance = valid_s1 && (!fill_valid_q || !fill_stall || !res_valid);
	assign cmd_stall = valid_s1 && !advance;

	// Hold the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Commit decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tool_q <= TOOL_LINE[1:0];
			grey_q <= 8'd0;
			acc_q <= 32'd0;
			cx_q <= 32'd0;
			cy_q <= 32'd0;
			tx_q <= 32'd0;
			ty_q <= 32'd0;
		end else if (advance) begin
			tool_q <= tool_n;
			grey_q <= grey_n;
			acc_q <= acc_n;
			cx_q <= cx_n;
			cy_q <= cy_n;
			tx_q <= tx_n;
			ty_q <= ty_n;
		end
	end

	// Load or drain the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			fill_valid_q <= 1'b1;
		end else if (!fill_stall) begin
			fill_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			fill_q <= res;
		end
	end

	assign fill_valid = fill_valid_q;
	assign fill = fill_q;

endmodule
